// ===== rtl/vsfn_pkg.sv =====
// Shared types and constants for the video stream format negotiator.
package vsfn_pkg;

	// Table geometry
	localparam int MAX_ENTRIES = 16;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Request function codes
	localparam logic [2:0] FUNC_LOAD    = 3'd0;
	localparam logic [2:0] FUNC_INIT    = 3'd1;
	localparam logic [2:0] FUNC_GET_MIN = 3'd2;
	localparam logic [2:0] FUNC_GET_MAX = 3'd3;
	localparam logic [2:0] FUNC_SET     = 3'd4;

	// Configuration register indexes
	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_MAX_PACKET  = 1'b1;

	// Pixel kinds
	localparam logic [1:0] KIND_YUYV = 2'd1;

	// Payload adjustment: 128 bytes off per full 1024-byte block
	localparam int BLOCK_SHIFT  = 10;
	localparam int CREDIT_SHIFT = 7;
	localparam logic [15:0] PACKET_RESET = 16'd1024;

	// One table entry as held in the table memory
	typedef struct packed {
		logic [7:0]  fmt;
		logic [7:0]  frm;
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] interval;
		logic [1:0]  kind;
	} entry_t;

endpackage

// ===== rtl/vsfn_calc.sv =====
// Frame size multiplier and payload size adjustment.
module vsfn_calc (
	input  logic        clk,
	input  logic [15:0] width,
	input  logic [15:0] height,
	input  logic [1:0]  kind,
	input  logic [15:0] max_packet,
	output logic [32:0] frame_size,
	output logic [15:0] payload
);

	logic [31:0] product_s1;
	logic        yuyv_s1;
	logic        partial;

	// Registered 16x16 product; YUYV doubles it on the way out
	always_ff @(posedge clk) begin
		product_s1 <= 32'(width) * 32'(height);
		yuyv_s1    <= (kind == vsfn_pkg::KIND_YUYV);
	end

	assign frame_size = yuyv_s1 ? {product_s1, 1'b0} : {1'b0, product_s1};

	// Above 1024 and not a whole number of blocks: drop 128 per full block
	assign partial = (max_packet > vsfn_pkg::PACKET_RESET) &&
		(max_packet[vsfn_pkg::BLOCK_SHIFT-1:0] != '0);
	assign payload = partial
		? max_packet - (16'(max_packet[15:vsfn_pkg::BLOCK_SHIFT]) << vsfn_pkg::CREDIT_SHIFT)
		: max_packet;

endmodule

// ===== rtl/video_stream_format_negotiator_unit.sv =====
// Top level of the video stream format negotiator.
//
// Usage: a request is accepted on a clock edge where start is high and busy
// is low; its fields sit on func, entry_* and req_* / is_commit. Exactly one
// result per request appears on the output ports for one cycle, marked by
// done; the receiver cannot hold it off and must take it then.
// A load request writes one table slot and answers with all fields zero on
// the next cycle; busy stays low, so loads may follow back to back.
// Control requests (init, get-min, get-max, set) walk the table memory
// through its single read port: one pass for the table-wide extremes, one
// for the frame range of the clamped format (init and set only) and one for
// the first matching entry. Each pass reads slots 0 to n-1, n being
// entry_count limited to 16; after the last pass come the size multiply
// and the output register (ST_MUL, then ST_OUT).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) used
// while idle. Reset clears the registers (entry_count 0, max_packet 1024)
// and leaves the table contents undefined until loaded.
module video_stream_format_negotiator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [2:0]  func,
	input  logic [3:0]  entry_slot,
	input  logic [7:0]  entry_format_id,
	input  logic [7:0]  entry_frame_id,
	input  logic [15:0] entry_width,
	input  logic [15:0] entry_height,
	input  logic [31:0] entry_interval,
	input  logic [1:0]  entry_kind,
	input  logic [7:0]  req_format_id,
	input  logic [7:0]  req_frame_id,
	input  logic        is_commit,
	output logic        done,
	output logic [7:0]  out_format_id,
	output logic [7:0]  out_frame_id,
	output logic [31:0] chosen_interval,
	output logic [32:0] max_frame_size,
	output logic [15:0] max_payload,
	output logic [7:0]  lowest_format,
	output logic [7:0]  highest_format,
	output logic        apply_valid,
	output logic [3:0]  apply_slot,
	output logic        status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_ALL,
		ST_SCAN_FMT,
		ST_SCAN_MATCH,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [4:0]  entry_count_q;
	logic [15:0] max_packet_q;

	// Table memory and its read pipeline
	vsfn_pkg::entry_t mem [vsfn_pkg::MAX_ENTRIES];
	vsfn_pkg::entry_t rd_s1;
	logic             rd_vld_s1;
	logic [vsfn_pkg::SLOT_W-1:0] rd_slot_s1;
	logic [vsfn_pkg::CNT_W-1:0]  addr_q;

	// Request context
	logic [2:0] func_q;
	logic       commit_q;
	logic [7:0] fmt_q;
	logic [7:0] frm_q;

	// Table-wide extremes
	logic       any_q;
	logic [7:0] fmt_lo_q, fmt_hi_q, frm_lo_q, frm_hi_q;

	// Frame range of the chosen format
	logic       seen_q;
	logic [7:0] flo_q, fhi_q;

	// Match result
	logic                        found_q;
	logic [vsfn_pkg::SLOT_W-1:0] slot_q;
	vsfn_pkg::entry_t            hit_q;

	// Output registers
	logic        done_q;
	logic [7:0]  out_fmt_q, out_frm_q, lo_fmt_q, hi_fmt_q;
	logic [31:0] interval_q;
	logic [32:0] size_q;
	logic [15:0] payload_q;
	logic        apply_q;
	logic [3:0]  apply_slot_q;
	logic        status_q;

	logic                       accept;
	logic                       load_wr;
	logic [vsfn_pkg::CNT_W-1:0] scan_n;
	logic                       issue;
	logic                       pass_end;
	logic [7:0]                 fmt_cl, frm_cl;
	logic [32:0]                calc_size;
	logic [15:0]                calc_payload;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign load_wr = accept && (func == vsfn_pkg::FUNC_LOAD);

	// Scan bounds: entry_count limited to the table depth
	assign scan_n = (entry_count_q > vsfn_pkg::CNT_W'(vsfn_pkg::MAX_ENTRIES))
		? vsfn_pkg::CNT_W'(vsfn_pkg::MAX_ENTRIES) : vsfn_pkg::CNT_W'(entry_count_q);
	assign issue    = (addr_q < scan_n);
	assign pass_end = !issue && !rd_vld_s1;

	// Clamps of the requested indices
	always_comb begin
		fmt_cl = fmt_q;
		if (fmt_cl < fmt_lo_q) fmt_cl = fmt_lo_q;
		if (fmt_cl > fmt_hi_q) fmt_cl = fmt_hi_q;
		frm_cl = frm_q;
		if (frm_cl < flo_q) frm_cl = flo_q;
		if (frm_cl > fhi_q) frm_cl = fhi_q;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			max_packet_q  <= vsfn_pkg::PACKET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vsfn_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[4:0];
				vsfn_pkg::REG_MAX_PACKET:  max_packet_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table memory: one write port for loads, one registered read port
	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[entry_slot] <= '{fmt: entry_format_id, frm: entry_frame_id,
				width: entry_width, height: entry_height,
				interval: entry_interval, kind: entry_kind};
		end
		rd_s1 <= mem[addr_q[vsfn_pkg::SLOT_W-1:0]];
	end

	vsfn_calc u_calc (
		.clk        (clk),
		.width      (hit_q.width),
		.height     (hit_q.height),
		.kind       (hit_q.kind),
		.max_packet (max_packet_q),
		.frame_size (calc_size),
		.payload    (calc_payload)
	);

	// Request sequencer: up to three table passes, then the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			rd_slot_s1   <= '0;
			func_q       <= '0;
			commit_q     <= 1'b0;
			fmt_q        <= '0;
			frm_q        <= '0;
			any_q        <= 1'b0;
			fmt_lo_q     <= '0;
			fmt_hi_q     <= '0;
			frm_lo_q     <= '0;
			frm_hi_q     <= '0;
			seen_q       <= 1'b0;
			flo_q        <= '0;
			fhi_q        <= '0;
			found_q      <= 1'b0;
			slot_q       <= '0;
			hit_q        <= '0;
			done_q       <= 1'b0;
			out_fmt_q    <= '0;
			out_frm_q    <= '0;
			lo_fmt_q     <= '0;
			hi_fmt_q     <= '0;
			interval_q   <= '0;
			size_q       <= '0;
			payload_q    <= '0;
			apply_q      <= 1'b0;
			apply_slot_q <= '0;
			status_q     <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_slot_s1 <= addr_q[vsfn_pkg::SLOT_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == vsfn_pkg::FUNC_LOAD || func > vsfn_pkg::FUNC_SET) begin
							// load acknowledge or unknown function: all-zero result
							done_q       <= 1'b1;
							out_fmt_q    <= '0;
							out_frm_q    <= '0;
							lo_fmt_q     <= '0;
							hi_fmt_q     <= '0;
							interval_q   <= '0;
							size_q       <= '0;
							payload_q    <= '0;
							apply_q      <= 1'b0;
							apply_slot_q <= '0;
							status_q     <= 1'b0;
						end else begin
							func_q   <= func;
							commit_q <= is_commit;
							fmt_q    <= req_format_id;
							frm_q    <= req_frame_id;
							any_q    <= 1'b0;
							fmt_lo_q <= '0;
							fmt_hi_q <= '0;
							frm_lo_q <= '0;
							frm_hi_q <= '0;
							seen_q   <= 1'b0;
							found_q  <= 1'b0;
							slot_q   <= '0;
							addr_q   <= '0;
							state_q  <= ST_SCAN_ALL;
						end
					end
				end
				ST_SCAN_ALL: begin
					if (issue) begin
						addr_q    <= addr_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end
					if (rd_vld_s1) begin
						any_q <= 1'b1;
						if (!any_q || rd_s1.fmt < fmt_lo_q) fmt_lo_q <= rd_s1.fmt;
						if (!any_q || rd_s1.fmt > fmt_hi_q) fmt_hi_q <= rd_s1.fmt;
						if (!any_q || rd_s1.frm < frm_lo_q) frm_lo_q <= rd_s1.frm;
						if (!any_q || rd_s1.frm > frm_hi_q) frm_hi_q <= rd_s1.frm;
					end
					if (pass_end) begin
						addr_q <= '0;
						case (func_q)
							vsfn_pkg::FUNC_GET_MIN: begin
								fmt_q   <= fmt_lo_q;
								frm_q   <= frm_lo_q;
								state_q <= ST_SCAN_MATCH;
							end
							vsfn_pkg::FUNC_GET_MAX: begin
								fmt_q   <= fmt_hi_q;
								frm_q   <= frm_hi_q;
								state_q <= ST_SCAN_MATCH;
							end
							default: begin
								if (any_q) begin
									fmt_q   <= fmt_cl;
									state_q <= ST_SCAN_FMT;
								end else begin
									state_q <= ST_SCAN_MATCH;
								end
							end
						endcase
					end
				end
				ST_SCAN_FMT: begin
					if (issue) begin
						addr_q    <= addr_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end
					// frame range over entries of the clamped format
					if (rd_vld_s1 && rd_s1.fmt == fmt_q) begin
						seen_q <= 1'b1;
						if (!seen_q || rd_s1.frm < flo_q) flo_q <= rd_s1.frm;
						if (!seen_q || rd_s1.frm > fhi_q) fhi_q <= rd_s1.frm;
					end
					if (pass_end) begin
						addr_q <= '0;
						if (seen_q) frm_q <= frm_cl;
						state_q <= ST_SCAN_MATCH;
					end
				end
				ST_SCAN_MATCH: begin
					if (issue) begin
						addr_q    <= addr_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end
					// keep the lowest matching slot
					if (rd_vld_s1 && !found_q && rd_s1.fmt == fmt_q && rd_s1.frm == frm_q) begin
						found_q <= 1'b1;
						slot_q  <= rd_slot_s1;
						hit_q   <= rd_s1;
					end
					if (pass_end) begin
						addr_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done_q       <= 1'b1;
					out_fmt_q    <= fmt_q;
					out_frm_q    <= frm_q;
					lo_fmt_q     <= fmt_lo_q;
					hi_fmt_q     <= fmt_hi_q;
					interval_q   <= found_q ? hit_q.interval : '0;
					size_q       <= found_q ? calc_size : '0;
					payload_q    <= calc_payload;
					apply_q      <= found_q && commit_q && (func_q == vsfn_pkg::FUNC_SET);
					apply_slot_q <= (found_q && commit_q && (func_q == vsfn_pkg::FUNC_SET))
						? 4'(slot_q) : '0;
					status_q     <= !found_q;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign out_format_id   = out_fmt_q;
	assign out_frame_id    = out_frm_q;
	assign chosen_interval = interval_q;
	assign max_frame_size  = size_q;
	assign max_payload     = payload_q;
	assign lowest_format   = lo_fmt_q;
	assign highest_format  = hi_fmt_q;
	assign apply_valid     = apply_q;
	assign apply_slot      = apply_slot_q;
	assign status          = status_q;

endmodule
